/* hw/rtl/hts_pkg.sv */
// ----------------------------------------------------------------------------
// hts_pkg
// Types and constants shared by the Huffman tree string decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hts_pkg;

  localparam int NODE_DEPTH_DEF = 256;

  localparam logic [7:0] LEAF_MARK  = 8'hFF;
  localparam logic [7:0] TERMINATOR = 8'h7C;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] node_index;
    logic [7:0] node_symbol;
    logic [7:0] node_left;
    logic [7:0] node_right;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_string;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic [7:0] left;
    logic [7:0] right;
  } node_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } push_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT_WAIT,
    ST_CUR_WAIT,
    ST_NEXT_WAIT,
    ST_FLUSH
  } walk_state_t;

endpackage

`default_nettype wire

/* hw/rtl/hts_node_mem.sv */
// ----------------------------------------------------------------------------
// hts_node_mem
// Node table: one write port, one read port with a registered, held output.
// Indexes beyond the table ignore writes and read as an all-zero node.
// ----------------------------------------------------------------------------
`default_nettype none

module hts_node_mem
  import hts_pkg::*;
#(
  parameter int NODE_DEPTH = NODE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       wr_en,
  input  wire logic [7:0] wr_idx,
  input  wire node_t      wr_node,
  input  wire logic       rd_en,
  input  wire logic [7:0] rd_idx,
  output node_t           rd_node
);

  localparam int AW = $clog2(NODE_DEPTH);

  node_t mem [NODE_DEPTH];
  node_t rd_q_r;
  logic  rd_oor_r;
  logic  wr_in_range;
  logic  rd_in_range;

  assign wr_in_range = {1'b0, wr_idx} < 9'(NODE_DEPTH);
  assign rd_in_range = {1'b0, rd_idx} < 9'(NODE_DEPTH);

  always_ff @(posedge clk) begin
    if (wr_en && wr_in_range) begin
      mem[wr_idx[AW-1:0]] <= wr_node;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r   <= mem[rd_idx[AW-1:0]];
      rd_oor_r <= !rd_in_range;
    end
  end

  assign rd_node = rd_oor_r ? '0 : rd_q_r;

endmodule

`default_nettype wire

/* hw/rtl/hts_walker.sv */
// ----------------------------------------------------------------------------
// hts_walker
// Tree walk sequencer: loads nodes, walks code bits through the node table
// one bit per read, and holds one pending symbol so the last one is marked.
// ----------------------------------------------------------------------------
`default_nettype none

module hts_walker
  import hts_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire in_item_t   in_item,
  output logic            in_stall,
  input  wire logic       cfg_valid,
  input  wire logic [7:0] cfg_data,
  output logic            cfg_ready,
  input  wire logic       out_free,
  output push_t           push,
  output logic            wr_en,
  output logic [7:0]      wr_idx,
  output node_t           wr_node,
  output logic            rd_en,
  output logic [7:0]      rd_idx,
  input  wire node_t      rd_node
);

  walk_state_t state_r, state_nxt;
  logic [7:0]  root_r, root_nxt;
  logic [7:0]  walk_pos_r, walk_pos_nxt;
  logic [7:0]  bits_r, bits_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  node_t       root_data_r, root_data_nxt;
  logic [7:0]  next_idx_r, next_idx_nxt;
  logic        pend_valid_r, pend_valid_nxt;
  logic [7:0]  pend_sym_r, pend_sym_nxt;
  logic        pend_term_r, pend_term_nxt;

  logic  accept;
  logic  rd_leaf;
  logic  term;
  node_t base;
  logic  [7:0] child;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign accept    = in_valid && !in_stall;

  assign wr_en   = accept && (in_item.func == FUNC_WRITE);
  assign wr_idx  = in_item.node_index;
  assign wr_node = '{symbol: in_item.node_symbol, left: in_item.node_left,
                     right: in_item.node_right};

  assign rd_leaf = (rd_node.left == LEAF_MARK);
  assign term    = rd_leaf && (rd_node.symbol == TERMINATOR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      root_r       <= '0;
      walk_pos_r   <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      root_r       <= root_nxt;
      walk_pos_r   <= walk_pos_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bits_r      <= bits_nxt;
    cnt_r       <= cnt_nxt;
    root_data_r <= root_data_nxt;
    next_idx_r  <= next_idx_nxt;
    pend_sym_r  <= pend_sym_nxt;
    pend_term_r <= pend_term_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    root_nxt       = root_r;
    walk_pos_nxt   = walk_pos_r;
    bits_nxt       = bits_r;
    cnt_nxt        = cnt_r;
    root_data_nxt  = root_data_r;
    next_idx_nxt   = next_idx_r;
    pend_valid_nxt = pend_valid_r;
    pend_sym_nxt   = pend_sym_r;
    pend_term_nxt  = pend_term_r;
    push           = '0;
    rd_en          = 1'b0;
    rd_idx         = root_r;
    base           = rd_node;
    child          = '0;

    case (state_r)
      ST_IDLE: begin
        if (cfg_valid) begin
          root_nxt     = cfg_data;
          walk_pos_nxt = cfg_data;
        end
        if (accept && (in_item.func == FUNC_DECODE)) begin
          rd_en     = 1'b1;
          rd_idx    = root_r;
          bits_nxt  = in_item.data_byte;
          state_nxt = ST_ROOT_WAIT;
        end
      end

      ST_ROOT_WAIT: begin
        if (rd_leaf) begin
          walk_pos_nxt = root_r;
          state_nxt    = ST_IDLE;
        end else begin
          root_data_nxt = rd_node;
          rd_en         = 1'b1;
          rd_idx        = walk_pos_r;
          state_nxt     = ST_CUR_WAIT;
        end
      end

      ST_CUR_WAIT: begin
        base         = rd_leaf ? root_data_r : rd_node;
        child        = bits_r[7] ? base.right : base.left;
        rd_en        = 1'b1;
        rd_idx       = child;
        next_idx_nxt = child;
        bits_nxt     = {bits_r[6:0], 1'b0};
        cnt_nxt      = '0;
        state_nxt    = ST_NEXT_WAIT;
      end

      ST_NEXT_WAIT: begin
        if (!(rd_leaf && pend_valid_r && !out_free)) begin
          if (rd_leaf) begin
            push.valid                = pend_valid_r;
            push.item.symbol          = pend_sym_r;
            push.item.end_of_string   = pend_term_r;
            push.item.last_of_run     = 1'b0;
            pend_valid_nxt            = 1'b1;
            pend_sym_nxt              = rd_node.symbol;
            pend_term_nxt             = term;
            walk_pos_nxt              = root_r;
            base                      = root_data_r;
          end else begin
            walk_pos_nxt = next_idx_r;
            base         = rd_node;
          end
          if (term || (cnt_r == 3'd7)) begin
            state_nxt = ST_FLUSH;
          end else begin
            child        = bits_r[7] ? base.right : base.left;
            rd_en        = 1'b1;
            rd_idx       = child;
            next_idx_nxt = child;
            bits_nxt     = {bits_r[6:0], 1'b0};
            cnt_nxt      = cnt_r + 3'd1;
          end
        end
      end

      ST_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          push.valid              = 1'b1;
          push.item.symbol        = pend_sym_r;
          push.item.end_of_string = pend_term_r;
          push.item.last_of_run   = 1'b1;
          pend_valid_nxt          = 1'b0;
          state_nxt               = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/hts_out_reg.sv */
// ----------------------------------------------------------------------------
// hts_out_reg
// Output register for result transactions; holds its payload while stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module hts_out_reg
  import hts_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  output logic       out_free,
  output logic       out_valid,
  output out_item_t  out_item,
  input  wire logic  out_stall
);

  logic      valid_r;
  out_item_t item_r;

  assign out_free  = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push.valid) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      item_r <= push.item;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/huffman_tree_string_decoder_unit.sv */
// ----------------------------------------------------------------------------
// huffman_tree_string_decoder_unit
// Huffman tree walk decoder over a node table loaded by write transactions.
//
//   Channel  Direction  Handshake           Payload
//   in_      input      in_valid/in_stall   in_item (in_item_t)
//   out_     output     out_valid/out_stall out_item (out_item_t)
//   cfg_     input      cfg_valid/cfg_ready cfg_data (root node index)
//
// A node write is taken while idle. A decode transaction reads the root node,
// then the node at the walk position, then one node per code bit walked, up
// to eight or a terminator; a root that is a leaf ends it with no walk.
// Output stalls hold the walk when a symbol cannot be handed to the output
// register. Reset clears the root to zero; the node table is undefined until
// written.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_tree_string_decoder_unit
  import hts_pkg::*;
#(
  parameter int NODE_DEPTH = NODE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire in_item_t   in_item,
  output logic            in_stall,
  output logic            out_valid,
  output out_item_t       out_item,
  input  wire logic       out_stall,
  input  wire logic       cfg_valid,
  input  wire logic [7:0] cfg_data,
  output logic            cfg_ready
);

  logic       out_free;
  push_t      push;
  logic       wr_en;
  logic [7:0] wr_idx;
  node_t      wr_node;
  logic       rd_en;
  logic [7:0] rd_idx;
  node_t      rd_node;

  hts_node_mem #(
    .NODE_DEPTH (NODE_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_node (wr_node),
    .rd_en   (rd_en),
    .rd_idx  (rd_idx),
    .rd_node (rd_node)
  );

  hts_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .out_free  (out_free),
    .push      (push),
    .wr_en     (wr_en),
    .wr_idx    (wr_idx),
    .wr_node   (wr_node),
    .rd_en     (rd_en),
    .rd_idx    (rd_idx),
    .rd_node   (rd_node)
  );

  hts_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall)
  );

endmodule

`default_nettype wire
